FILE: src/qxmm_pkg.sv
// Shared constants, types and helpers for the quad X motor mixer.
`timescale 1ns / 1ps
package qxmm_pkg;

    localparam int DUTY_BITS   = 16;
    localparam int FIELD_BITS  = 16;
    localparam int SUM_BITS    = FIELD_BITS + 2;
    localparam int CLAMP_BITS  = 15;
    localparam int ONE_Q14     = 16384;
    localparam int SCALE_STEPS = 1000;
    localparam int X_BITS      = 10;
    localparam int MAG_BITS    = FIELD_BITS;
    localparam int PROD_BITS   = X_BITS + MAG_BITS;
    localparam int CNT_BITS    = $clog2(MAG_BITS);
    localparam int REM_BITS    = X_BITS;
    localparam int CAP_BITS    = 21;

    localparam logic [CAP_BITS-1:0] DUTY_CAP =
        CAP_BITS'((64'd1 << DUTY_BITS) - 64'd1);

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_MIX    = 2'd1;
    localparam logic [1:0] MODE_ARM    = 2'd2;
    localparam logic [1:0] MODE_DISARM = 2'd3;

    localparam logic [1:0] CFG_MIN_PWM   = 2'd0;
    localparam logic [1:0] CFG_MAX_PWM   = 2'd1;
    localparam logic [1:0] CFG_ARM_HOLD  = 2'd2;

    localparam logic [15:0] RST_MIN_PWM  = 16'd3277;
    localparam logic [15:0] RST_MAX_PWM  = 16'd6554;
    localparam logic [15:0] RST_ARM_HOLD = 16'd3000;

    localparam logic [1:0] MOTOR_FR = 2'd0;
    localparam logic [1:0] MOTOR_FL = 2'd1;
    localparam logic [1:0] MOTOR_RR = 2'd2;
    localparam logic [1:0] MOTOR_RL = 2'd3;

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] sum;
    } t_duty_req;

    // Saturate a non-negative duty at the top of the duty range.
    function automatic logic [15:0] sat_duty(input logic [16:0] v);
        logic [CAP_BITS-1:0] wide;
        begin
            wide = CAP_BITS'(v);
            if (wide > DUTY_CAP) begin
                sat_duty = DUTY_CAP[15:0];
            end else begin
                sat_duty = v[15:0];
            end
        end
    endfunction

endpackage

FILE: src/qxmm_duty_serial.sv
// Bit-serial duty unit: clamps one motor sum, scales it and maps it to a duty count.
`timescale 1ns / 1ps
module qxmm_duty_serial (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qxmm_pkg::t_duty_req i_req,
    input  logic [15:0]         i_min_pwm,
    input  logic [15:0]         i_max_pwm,
    output logic                o_done,
    output logic [15:0]         o_duty
);
    import qxmm_pkg::*;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(X_BITS - 1);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(MAG_BITS - 1);
    localparam logic [REM_BITS:0]   DIVISOR  = (REM_BITS+1)'(SCALE_STEPS);
    localparam logic [SUM_BITS-1:0] ONE_SUM  = SUM_BITS'(ONE_Q14);

    logic [1:0]            r_phase;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [X_BITS-1:0]     r_x;
    logic [MAG_BITS-1:0]   r_mag;
    logic                  r_neg;
    logic [15:0]           r_min;
    logic [PROD_BITS-1:0]  r_acc;
    logic [REM_BITS-1:0]   r_rem;
    logic [MAG_BITS-1:0]   r_dvd;
    logic                  r_done;
    logic [15:0]           r_duty;

    logic [CLAMP_BITS-1:0] w_clamp;
    logic [24:0]           w_x1000;
    logic signed [16:0]    w_diff;
    logic [MAG_BITS-1:0]   w_mag;
    logic [PROD_BITS-1:0]  n_acc;
    logic [REM_BITS:0]     w_trial;
    logic                  w_qbit;
    logic [REM_BITS-1:0]   n_rem;
    logic signed [17:0]    w_duty;
    logic [15:0]           n_duty;

    always_comb begin
        if (i_req.sum[SUM_BITS-1]) begin
            w_clamp = '0;
        end else if (i_req.sum > ONE_SUM) begin
            w_clamp = CLAMP_BITS'(ONE_Q14);
        end else begin
            w_clamp = i_req.sum[CLAMP_BITS-1:0];
        end
        // times 1000 as 1024 - 16 - 8
        w_x1000 = 25'({w_clamp, 10'b0}) - 25'({w_clamp, 4'b0}) - 25'({w_clamp, 3'b0});
        w_diff  = $signed({1'b0, i_max_pwm}) - $signed({1'b0, i_min_pwm});
        w_mag   = w_diff[16] ? 16'(-w_diff) : w_diff[15:0];

        n_acc   = {r_acc[PROD_BITS-2:0], 1'b0} + (r_x[X_BITS-1] ? PROD_BITS'(r_mag) : '0);

        w_trial = {r_rem, r_dvd[MAG_BITS-1]};
        w_qbit  = (w_trial >= DIVISOR);
        n_rem   = w_qbit ? REM_BITS'(w_trial - DIVISOR) : w_trial[REM_BITS-1:0];

        if (r_neg) begin
            w_duty = $signed({2'b0, r_min}) - $signed({2'b0, r_dvd});
        end else begin
            w_duty = $signed({2'b0, r_min}) + $signed({2'b0, r_dvd});
        end
        n_duty = w_duty[17] ? 16'd0 : sat_duty(w_duty[16:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_req.start) begin
                        r_phase <= PH_MUL;
                        r_cnt   <= MUL_LAST;
                    end
                end
                PH_MUL: begin
                    if (r_cnt == '0) begin
                        r_phase <= PH_DIV;
                        r_cnt   <= DIV_LAST;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                PH_DIV: begin
                    if (r_cnt == '0) begin
                        r_phase <= PH_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                PH_FIN: begin
                    r_phase <= PH_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_phase)
            PH_IDLE: begin
                if (i_req.start) begin
                    r_x   <= w_x1000[23:14];
                    r_mag <= w_mag;
                    r_neg <= w_diff[16];
                    r_min <= i_min_pwm;
                    r_acc <= '0;
                end
            end
            PH_MUL: begin
                r_acc <= n_acc;
                r_x   <= {r_x[X_BITS-2:0], 1'b0};
                if (r_cnt == '0) begin
                    // product is below 1000 * 2^16, so its top bits seed the remainder
                    r_rem <= n_acc[PROD_BITS-1:MAG_BITS];
                    r_dvd <= n_acc[MAG_BITS-1:0];
                end
            end
            PH_DIV: begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[MAG_BITS-2:0], w_qbit};
            end
            PH_FIN: begin
                r_duty <= n_duty;
            end
            default: begin
                r_duty <= r_duty;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_duty = r_duty;

endmodule

FILE: src/quad_x_motor_mixer_pwm_unit.sv
// Top level of the quad X motor mixer: arming control, motor sequencing and result buffering.
`timescale 1ns / 1ps
// Quad X motor mixer with duty-count output and arming hold. Tick, arm request and
// disarm requests are handled in the cycle they are accepted; arm and disarm leave a
// minimum-duty result in the result register that moves to the output once it is
// free. An armed mix request runs the four motors one after another through a single
// bit-serial duty unit: per motor a load step, a shift-add multiply of the range by the
// scaled motor sum, a long division by 1000 and a finish step. Mix requests while
// disarmed, arm requests while armed and all ticks give no result. A result waiting
// at the output does not hold off the next request; a second pending result or a
// running mix does.
module quad_x_motor_mixer_pwm_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_mode,
    input  logic signed [qxmm_pkg::FIELD_BITS-1:0] i_throttle_cmd,
    input  logic signed [qxmm_pkg::FIELD_BITS-1:0] i_roll_cmd,
    input  logic signed [qxmm_pkg::FIELD_BITS-1:0] i_pitch_cmd,
    input  logic signed [qxmm_pkg::FIELD_BITS-1:0] i_yaw_cmd,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [15:0]                   i_cfg_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [15:0]                   o_duty_front_right,
    output logic [15:0]                   o_duty_front_left,
    output logic [15:0]                   o_duty_rear_right,
    output logic [15:0]                   o_duty_rear_left,
    output logic                          o_is_armed
);
    import qxmm_pkg::*;

    logic [15:0] r_min_pwm;
    logic [15:0] r_max_pwm;
    logic [15:0] r_arm_hold;

    logic        r_armed;
    logic        r_arming;
    logic [15:0] r_hold;

    logic        r_busy;
    logic        r_start;
    logic [1:0]  r_motor;
    logic signed [FIELD_BITS-1:0] r_thr;
    logic signed [FIELD_BITS-1:0] r_roll;
    logic signed [FIELD_BITS-1:0] r_pitch;
    logic signed [FIELD_BITS-1:0] r_yaw;

    logic        r_res_valid;
    logic [15:0] r_res_duty [4];
    logic        r_res_armed;

    logic        r_out_valid;
    logic [15:0] r_out_fr;
    logic [15:0] r_out_fl;
    logic [15:0] r_out_rr;
    logic [15:0] r_out_rl;
    logic        r_out_armed;

    logic        w_in_acc;
    logic        w_out_free;
    logic [15:0] n_hold;
    logic [15:0] w_lo;
    logic signed [SUM_BITS-1:0] w_sum;
    t_duty_req   w_req;
    logic        w_done;
    logic [15:0] w_duty;

    assign o_stall    = r_busy | r_res_valid;
    assign w_in_acc   = i_valid & ~o_stall;
    assign w_out_free = ~r_out_valid | ~i_stall;
    assign n_hold     = (r_hold == 16'hFFFF) ? r_hold : r_hold + 16'd1;
    assign w_lo       = sat_duty({1'b0, r_min_pwm});

    // X-frame signs: pitch adds on the front pair, roll on the right side,
    // yaw on the front-left / rear-right diagonal.
    always_comb begin
        logic signed [SUM_BITS-1:0] t;
        logic signed [SUM_BITS-1:0] r;
        logic signed [SUM_BITS-1:0] p;
        logic signed [SUM_BITS-1:0] y;
        t = SUM_BITS'(r_thr);
        r = SUM_BITS'(r_roll);
        p = SUM_BITS'(r_pitch);
        y = SUM_BITS'(r_yaw);
        case (r_motor)
            MOTOR_FR: w_sum = t + p + r - y;
            MOTOR_FL: w_sum = t + p - r + y;
            MOTOR_RR: w_sum = t - p + r + y;
            MOTOR_RL: w_sum = t - p - r - y;
            default:  w_sum = t;
        endcase
        w_req.start = r_start;
        w_req.sum   = w_sum;
    end

    qxmm_duty_serial u_duty (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_min_pwm (r_min_pwm),
        .i_max_pwm (r_max_pwm),
        .o_done    (w_done),
        .o_duty    (w_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pwm  <= RST_MIN_PWM;
            r_max_pwm  <= RST_MAX_PWM;
            r_arm_hold <= RST_ARM_HOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_PWM:  r_min_pwm  <= i_cfg_data;
                CFG_MAX_PWM:  r_max_pwm  <= i_cfg_data;
                CFG_ARM_HOLD: r_arm_hold <= i_cfg_data;
                default: begin
                    r_min_pwm <= r_min_pwm;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_arming    <= 1'b0;
            r_hold      <= '0;
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_motor     <= MOTOR_FR;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;

            if (w_in_acc) begin
                case (i_mode)
                    MODE_TICK: begin
                        if (r_arming) begin
                            r_hold <= n_hold;
                            if (n_hold >= r_arm_hold) begin
                                r_armed  <= 1'b1;
                                r_arming <= 1'b0;
                            end
                        end
                    end
                    MODE_MIX: begin
                        if (r_armed) begin
                            r_busy  <= 1'b1;
                            r_start <= 1'b1;
                            r_motor <= MOTOR_FR;
                        end
                    end
                    MODE_ARM: begin
                        if (!r_armed) begin
                            r_hold      <= '0;
                            r_res_valid <= 1'b1;
                            if (r_arm_hold == '0) begin
                                r_armed  <= 1'b1;
                                r_arming <= 1'b0;
                            end else begin
                                r_arming <= 1'b1;
                            end
                        end
                    end
                    MODE_DISARM: begin
                        r_armed     <= 1'b0;
                        r_arming    <= 1'b0;
                        r_hold      <= '0;
                        r_res_valid <= 1'b1;
                    end
                    default: begin
                        r_hold <= r_hold;
                    end
                endcase
            end

            // advance to the next motor, or close out the request after the last one
            if (w_done) begin
                if (r_motor == MOTOR_RL) begin
                    r_busy      <= 1'b0;
                    r_res_valid <= 1'b1;
                end else begin
                    r_motor <= r_motor + 2'd1;
                    r_start <= 1'b1;
                end
            end

            if (w_out_free) begin
                r_out_valid <= r_res_valid;
                if (r_res_valid) begin
                    r_res_valid <= 1'b0;
                end
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_mode == MODE_MIX) && r_armed) begin
            r_thr   <= i_throttle_cmd;
            r_roll  <= i_roll_cmd;
            r_pitch <= i_pitch_cmd;
            r_yaw   <= i_yaw_cmd;
        end
        if (w_in_acc && (i_mode == MODE_ARM) && !r_armed) begin
            r_res_duty[0] <= w_lo;
            r_res_duty[1] <= w_lo;
            r_res_duty[2] <= w_lo;
            r_res_duty[3] <= w_lo;
            r_res_armed   <= (r_arm_hold == '0);
        end else if (w_in_acc && (i_mode == MODE_DISARM)) begin
            r_res_duty[0] <= w_lo;
            r_res_duty[1] <= w_lo;
            r_res_duty[2] <= w_lo;
            r_res_duty[3] <= w_lo;
            r_res_armed   <= 1'b0;
        end else if (w_done) begin
            r_res_duty[r_motor] <= w_duty;
            r_res_armed         <= r_armed;
        end
        if (w_out_free && r_res_valid) begin
            r_out_fr    <= r_res_duty[0];
            r_out_fl    <= r_res_duty[1];
            r_out_rr    <= r_res_duty[2];
            r_out_rl    <= r_res_duty[3];
            r_out_armed <= r_res_armed;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_duty_front_right = r_out_fr;
    assign o_duty_front_left  = r_out_fl;
    assign o_duty_rear_right  = r_out_rr;
    assign o_duty_rear_left   = r_out_rl;
    assign o_is_armed         = r_out_armed;

    a_busy_res_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_res_valid))
        else $error("mix engine running while a result is pending");

    a_arm_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_armed && r_arming))
        else $error("armed and arming at once");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy)
        else $error("duty unit finished outside a mix request");

    a_last_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && (r_motor == MOTOR_RL)) |=> (r_res_valid || r_out_valid))
        else $error("last motor finished without a result");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_busy && !w_done))
        else $error("duty unit started outside a mix request");

endmodule
